FILE: rtl/cfs_pkg.sv
package cfs_pkg;

	// phase codes
	localparam logic [2:0] PH_IDLE    = 3'd0;
	localparam logic [2:0] PH_WAIT    = 3'd1;
	localparam logic [2:0] PH_NOFLASH = 3'd2;
	localparam logic [2:0] PH_AF      = 3'd3;
	localparam logic [2:0] PH_PRE     = 3'd4;
	localparam logic [2:0] PH_MAIN    = 3'd5;

	// lock codes
	localparam logic [1:0] LK_LOCKED  = 2'd0;
	localparam logic [1:0] LK_AF      = 2'd1;
	localparam logic [1:0] LK_CAPTURE = 2'd2;

	// flow codes
	localparam logic [2:0] FL_NONE        = 3'd0;
	localparam logic [2:0] FL_ASSIST      = 3'd1;
	localparam logic [2:0] FL_ASSIST_DONE = 3'd2;
	localparam logic [2:0] FL_TESTING     = 3'd3;
	localparam logic [2:0] FL_PRE_DONE    = 3'd4;
	localparam logic [2:0] FL_CAP_START   = 3'd5;
	localparam logic [2:0] FL_DONE        = 3'd6;

	// lamp commands
	localparam logic [1:0] CMD_NONE  = 2'd0;
	localparam logic [1:0] CMD_TORCH = 2'd1;
	localparam logic [1:0] CMD_MAIN  = 2'd2;
	localparam logic [1:0] CMD_OFF   = 2'd3;

	// actions
	localparam logic [1:0] ACT_FRAME   = 2'd0;
	localparam logic [1:0] ACT_TICK    = 2'd1;
	localparam logic [1:0] ACT_ARM_AF  = 2'd2;
	localparam logic [1:0] ACT_ARM_CAP = 2'd3;

	// converge state codes and flags
	localparam logic [7:0] ST_S1_OK      = 8'h10;
	localparam logic [7:0] ST_S1_FAIL    = 8'h11;
	localparam logic [7:0] ST_S1_RUNNING = 8'h12;
	localparam logic [7:0] ST_S1_QUICK   = 8'h16;
	localparam logic [7:0] FLAG_ON       = 8'h01;
	localparam logic [7:0] FLAG_CALC     = 8'h02;
	localparam logic [7:0] TORCH_LEVEL   = 8'd3;

	// flash modes
	localparam logic [1:0] MODE_AUTO = 2'd1;
	localparam logic [1:0] MODE_ON   = 2'd2;

	// configuration register indexes
	localparam logic [1:0] CFG_FLASH_MODE  = 2'd0;
	localparam logic [1:0] CFG_SINGLE_SHOT = 2'd1;
	localparam logic [1:0] CFG_SECONDARY   = 2'd2;

endpackage

FILE: rtl/camera_flash_sequencer.sv
// camera flash sequencer
//
// input channel (in_valid / in_ready) carries one beat per metadata frame,
// flash tick or arm request; output channel (out_valid / out_ready) returns
// exactly one result beat per input beat, in order.
// configuration: cfg_we writes cfg_data into register cfg_index at the clock
// edge (0 flash mode, 1 single shot, 2 secondary sensor); write only while
// no beat is in flight.
// path: an input beat is captured in the input register, the decision
// logic runs between that register and the result register, and the result
// shows on out_valid once the result register has loaded it.
// throughput: one beat per cycle while out_ready is high; the sequencer state
// is updated in the same edge that loads the result register, so the next beat sees it at once.
// stall: when out_ready is low the result register holds, the input
// register may still take one beat, and in_ready then drops until the
// receiver takes the waiting result.
// reset (arst_n low): phase idle, locked, lamp off, flow none, recorded
// rate, main level and drop count zero; flash mode off, single shot on,
// primary sensor; both channels empty.
module camera_flash_sequencer
	import cfs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [1:0]  cfg_data,
	// input beat
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  action,
	input  logic [7:0]  ae_converge,
	input  logic [7:0]  af_converge,
	input  logic [7:0]  ae_flash_flag,
	input  logic [7:0]  af_assist_flag,
	input  logic [7:0]  ae_image_ready,
	input  logic [7:0]  preflash_state,
	input  logic [7:0]  preflash_ready,
	input  logic [7:0]  flash_energy,
	input  logic [15:0] rate_code,
	// result beat
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  lamp_command,
	output logic [7:0]  lamp_level,
	output logic [1:0]  drop_frames,
	output logic        exif_flash,
	output logic        preflash_notice,
	output logic [2:0]  phase,
	output logic [1:0]  lock_status,
	output logic [2:0]  flow_status
);

	// configuration registers
	logic [1:0] lamp_mode_q;
	logic       single_shot_q;
	logic       secondary_q;

	// sequencer state
	logic [2:0]  phase_q;
	logic [1:0]  lock_q;
	logic        requested_q;
	logic        lit_q;
	logic [2:0]  flow_q;
	logic [15:0] rate_q;
	logic [7:0]  level_q;
	logic [1:0]  drop_q;

	// input register
	logic        valid_s1;
	logic [1:0]  action_s1;
	logic [7:0]  ae_s1, af_s1, ae_flag_s1, af_flag_s1;
	logic [7:0]  img_ready_s1, pre_state_s1, pre_ready_s1, energy_s1;
	logic [15:0] rate_s1;

	// result register
	logic        valid_s2;
	logic [1:0]  cmd_s2;
	logic [7:0]  level_s2;
	logic [1:0]  drop_s2;
	logic        exif_s2;
	logic        notice_s2;
	logic [2:0]  phase_s2;
	logic [1:0]  lock_s2;
	logic [2:0]  flow_s2;

	logic advance;
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || !valid_s2 || out_ready;

	// next state and result of the beat in the input register
	logic [2:0]  phase_n;
	logic [1:0]  lock_n;
	logic        requested_n;
	logic        lit_n;
	logic [2:0]  flow_n;
	logic [15:0] rate_n;
	logic [7:0]  level_n;
	logic [1:0]  drop_n;
	logic [1:0]  cmd;
	logic [7:0]  lvl;
	logic        exif;
	logic        notice;
	logic [2:0]  p;
	logic        go;
	logic        mode_act;
	logic        pre_mode_act;
	logic        flag_on;
	logic        calc;
	logic        want;
	logic        af_done;

	function automatic logic ae_image_ready_zero(input logic [7:0] v);
		return v == 8'd0;
	endfunction

	always_comb begin
		mode_act     = (lamp_mode_q == MODE_AUTO) || (lamp_mode_q == MODE_ON);
		pre_mode_act = single_shot_q && !secondary_q && mode_act;
		flag_on      = (af_flag_s1 == FLAG_ON) || (ae_flag_s1 == FLAG_ON);
		calc         = (af_flag_s1 == FLAG_CALC) || (ae_flag_s1 == FLAG_CALC);
		af_done      = (af_s1 == ST_S1_OK) || (af_s1 == ST_S1_FAIL);
		// flash decision for the wait phase
		if (secondary_q) begin
			want = 1'b0;
		end else if (lock_q == LK_AF) begin
			want = mode_act && flag_on;
		end else if (!single_shot_q) begin
			want = 1'b0;
		end else begin
			want = (lamp_mode_q == MODE_ON) || ((lamp_mode_q == MODE_AUTO) && flag_on);
		end

		phase_n     = phase_q;
		lock_n      = lock_q;
		requested_n = requested_q;
		lit_n       = lit_q;
		flow_n      = flow_q;
		rate_n      = rate_q;
		level_n     = level_q;
		drop_n      = drop_q;
		cmd         = CMD_NONE;
		lvl         = 8'd0;
		exif        = 1'b0;
		notice      = 1'b0;
		p           = phase_q;
		go          = 1'b1;

		case (action_s1)
			ACT_ARM_AF: begin
				lock_n = LK_AF;
			end
			ACT_ARM_CAP: begin
				lock_n = LK_CAPTURE;
			end
			ACT_TICK: begin
				if (phase_q == PH_MAIN && !lit_q) begin
					cmd    = CMD_MAIN;
					lvl    = level_q;
					lit_n  = 1'b1;
					flow_n = FL_CAP_START;
				end else if (flow_q == FL_CAP_START) begin
					cmd         = CMD_OFF;
					requested_n = 1'b0;
					lit_n       = 1'b0;
					flow_n      = FL_DONE;
					phase_n     = PH_IDLE;
				end
			end
			default: begin
				if (lock_q != LK_LOCKED) begin
					if (p == PH_IDLE) begin
						rate_n = 16'd0;
						if (ae_s1 == ST_S1_RUNNING) begin
							phase_n = PH_WAIT;
							p       = PH_WAIT;
						end else begin
							if (ae_s1 == ST_S1_QUICK) begin
								lock_n = LK_LOCKED;
							end
							go = 1'b0;
						end
					end
					if (go && p == PH_WAIT) begin
						if (ae_s1 == ST_S1_RUNNING) begin
							go = 1'b0;
						end else if (!secondary_q && ae_image_ready_zero(img_ready_s1)) begin
							go = 1'b0;
						end else if (calc && ((lock_q == LK_AF) ? mode_act : pre_mode_act)) begin
							go = 1'b0;
						end else if (want) begin
							cmd         = CMD_TORCH;
							lvl         = TORCH_LEVEL;
							requested_n = 1'b1;
							lit_n       = 1'b1;
							notice      = 1'b1;
							if (lock_q == LK_AF) begin
								phase_n = PH_AF;
								flow_n  = FL_ASSIST;
							end else begin
								phase_n = PH_PRE;
								flow_n  = FL_TESTING;
								exif    = 1'b1;
							end
							go = 1'b0;
						end else begin
							// no flash needed, fall through into the no-flash phase
							phase_n = PH_NOFLASH;
							flow_n  = FL_DONE;
							p       = PH_NOFLASH;
						end
					end
					if (go && p == PH_NOFLASH) begin
						if (af_done || secondary_q) begin
							phase_n = PH_IDLE;
							lock_n  = LK_LOCKED;
						end
						go = 1'b0;
					end
					if (go && (p == PH_AF || p == PH_PRE)) begin
						if (pre_ready_s1 == 8'd0 || pre_state_s1 == 8'd0 || energy_s1 == 8'd0) begin
							go = 1'b0;
						end
						if (go && p == PH_AF && rate_q == 16'd0) begin
							rate_n = rate_s1;
						end
						if (go && lock_q == LK_AF && !af_done) begin
							go = 1'b0;
						end
						if (go) begin
							if (p == PH_AF) begin
								if (requested_q) begin
									cmd         = CMD_OFF;
									drop_n      = (rate_n != rate_s1) ? 2'd2 : 2'd1;
									requested_n = 1'b0;
									lit_n       = 1'b0;
								end
								flow_n  = FL_ASSIST_DONE;
								phase_n = PH_IDLE;
							end else begin
								if (requested_q && lit_q) begin
									cmd    = CMD_OFF;
									drop_n = 2'd2;
									lit_n  = 1'b0;
								end
								level_n = energy_s1 - 8'd1;
								flow_n  = FL_PRE_DONE;
								phase_n = PH_MAIN;
							end
							lock_n = LK_LOCKED;
						end
					end
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lamp_mode_q   <= 2'd0;
			single_shot_q <= 1'b1;
			secondary_q   <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_FLASH_MODE:  lamp_mode_q   <= cfg_data;
				CFG_SINGLE_SHOT: single_shot_q <= cfg_data[0];
				CFG_SECONDARY:   secondary_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			lock_q      <= LK_LOCKED;
			requested_q <= 1'b0;
			lit_q       <= 1'b0;
			flow_q      <= FL_NONE;
			rate_q      <= 16'd0;
			level_q     <= 8'd0;
			drop_q      <= 2'd0;
		end else if (advance) begin
			phase_q     <= phase_n;
			lock_q      <= lock_n;
			requested_q <= requested_n;
			lit_q       <= lit_n;
			flow_q      <= flow_n;
			rate_q      <= rate_n;
			level_q     <= level_n;
			drop_q      <= drop_n;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			action_s1    <= action;
			ae_s1        <= ae_converge;
			af_s1        <= af_converge;
			ae_flag_s1   <= ae_flash_flag;
			af_flag_s1   <= af_assist_flag;
			img_ready_s1 <= ae_image_ready;
			pre_state_s1 <= preflash_state;
			pre_ready_s1 <= preflash_ready;
			energy_s1    <= flash_energy;
			rate_s1      <= rate_code;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || out_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			cmd_s2    <= cmd;
			level_s2  <= lvl;
			drop_s2   <= drop_n;
			exif_s2   <= exif;
			notice_s2 <= notice;
			phase_s2  <= phase_n;
			lock_s2   <= lock_n;
			flow_s2   <= flow_n;
		end
	end

	assign out_valid       = valid_s2;
	assign lamp_command    = cmd_s2;
	assign lamp_level      = level_s2;
	assign drop_frames     = drop_s2;
	assign exif_flash      = exif_s2;
	assign preflash_notice = notice_s2;
	assign phase           = phase_s2;
	assign lock_status     = lock_s2;
	assign flow_status     = flow_s2;

`ifndef SYNTHESIS
	a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && valid_s2 && !out_ready))
		else $error("input stalled without a stalled result");

	a_torch_level: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && lamp_command == CMD_TORCH) |-> (lamp_level == TORCH_LEVEL))
		else $error("torch on with wrong level");

	a_exif_preflash: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && exif_flash) |-> (preflash_notice && phase == PH_PRE))
		else $error("flash fired record outside pre-flash start");

	a_lock_code: assert property (@(posedge clk) disable iff (!arst_n)
		lock_q != 2'd3)
		else $error("lock state took an unused code");

	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> ($stable(phase_q) && $stable(flow_q) && $stable(lock_q)))
		else $error("sequencer state moved without a beat");
`endif

endmodule
